/* rtl/core/ewpe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the expander walk parity extractor.
// No dependencies; every other file of the block imports this package.
package ewpe_pkg;

  localparam int unsigned HALF_BITS_DEF = 10;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned INDEX_W    = 14;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned VERTEX_W   = 20;
  localparam int unsigned EDGE_W     = 3;
  localparam int unsigned SIDE_W     = 11;
  localparam int unsigned HALF_CFG_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MOD_STEPS   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BITS = 2'd1;

  localparam logic [SIDE_W-1:0]     SIDE_RESET = 11'd1024;
  localparam logic [HALF_CFG_W-1:0] HALF_RESET = 4'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_STEP  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  word_index;
    logic [DATA_W-1:0]   word_data;
    logic [VERTEX_W-1:0] start_vertex;
    logic [EDGE_W-1:0]   edge_req;
    logic                select_bit;
  } in_word_t;

  typedef struct packed {
    logic                parity;
    logic [VERTEX_W-1:0] vertex;
  } out_word_t;

  typedef struct packed {
    logic [SIDE_W-1:0]     side;
    logic [HALF_CFG_W-1:0] half_bits;
  } cfg_t;

  typedef struct packed {
    mode_e               op;
    logic [INDEX_W-1:0]  word_index;
    logic [DATA_W-1:0]   word_data;
    logic [VERTEX_W-1:0] start_vertex;
    logic                step_y;
    logic                step_odd;
    logic                step_sub;
    logic                select_bit;
  } cmd_t;

  // Bits per coordinate in use, saturated at the built coordinate width.
  function automatic logic [4:0] eff_half(input logic [HALF_CFG_W-1:0] hb,
                                          input int unsigned limit);
    eff_half = (32'(hb) > limit) ? 5'(limit) : 5'(hb);
  endfunction

endpackage

/* rtl/core/ewpe_front.sv */
`timescale 1ns / 1ps
// Front end: takes input words and turns them into decoded commands.
// Depends on ewpe_pkg; feeds ewpe_queue.
module ewpe_front #(
  parameter int unsigned HALF_BITS = ewpe_pkg::HALF_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ewpe_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  ewpe_pkg::in_word_t  in_word_i,
  output logic                in_stall_o,
  input  logic                queue_full_i,
  output logic                push_o,
  output ewpe_pkg::cmd_t      cmd_o
);
  import ewpe_pkg::*;

  localparam int unsigned H_W = $clog2(HALF_BITS + 1);
  localparam int unsigned EDGE_SUB_BIT = 0;
  localparam int unsigned EDGE_ODD_BIT = 1;
  localparam int unsigned EDGE_Y_BIT   = 2;

  logic [H_W-1:0]         eff_h;
  logic [2*HALF_BITS:0]   vmask_w;
  logic                   seen_q;

  assign eff_h   = H_W'(eff_half(cfg_i.half_bits, HALF_BITS));
  assign vmask_w = ({{(2*HALF_BITS){1'b0}}, 1'b1} << {eff_h, 1'b0})
                 - {{(2*HALF_BITS){1'b0}}, 1'b1};

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && seen_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.op           = mode_e'(in_word_i.mode);
    cmd_o.word_index   = in_word_i.word_index;
    cmd_o.word_data    = in_word_i.word_data;
    cmd_o.start_vertex = in_word_i.start_vertex & VERTEX_W'(vmask_w);
    cmd_o.step_y       = in_word_i.edge_req[EDGE_Y_BIT];
    cmd_o.step_odd     = in_word_i.edge_req[EDGE_ODD_BIT];
    cmd_o.step_sub     = in_word_i.edge_req[EDGE_SUB_BIT];
    cmd_o.select_bit   = in_word_i.select_bit;
  end

  // The front end is live as soon as reset is released; seen_q is held high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b1;
    end else begin
      seen_q <= 1'b1;
    end
  end

endmodule

/* rtl/core/ewpe_queue.sv */
`timescale 1ns / 1ps
// Command queue between the front end and the back end.
// Depends on ewpe_pkg for the command type and the queue depth.
module ewpe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ewpe_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ewpe_pkg::cmd_t  cmd_o
);
  import ewpe_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

/* rtl/core/ewpe_mod_unit.sv */
`timescale 1ns / 1ps
// Iterative remainder unit: value mod modulus, several bits per clock.
// Depends on ewpe_pkg for the modulus width and the bits per cycle.
module ewpe_mod_unit #(
  parameter int unsigned VALUE_W = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [VALUE_W-1:0]          value_i,
  input  logic [ewpe_pkg::SIDE_W-1:0] modulus_i,
  output logic                        done_o,
  output logic [ewpe_pkg::SIDE_W-1:0] rem_o
);
  import ewpe_pkg::*;

  localparam int unsigned NCYC  = (VALUE_W + MOD_STEPS - 1) / MOD_STEPS;
  localparam int unsigned PAD_W = NCYC * MOD_STEPS;
  localparam int unsigned CNT_W = $clog2(NCYC + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PAD_W-1:0]   shreg_q;
  logic [SIDE_W-1:0]  rem_q, rem_d;
  logic [SIDE_W-1:0]  mod_q;

  always_comb begin
    logic [SIDE_W:0]   t;
    logic [SIDE_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < MOD_STEPS; k++) begin
      t = {r, shreg_q[PAD_W-1-k]};
      if (t >= {1'b0, mod_q}) begin
        t = t - {1'b0, mod_q};
      end
      r = t[SIDE_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NCYC);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= PAD_W'(value_i);
      rem_q   <= '0;
      mod_q   <= modulus_i;
    end else if (busy_q) begin
      shreg_q <= shreg_q << MOD_STEPS;
      rem_q   <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_o < mod_q))
    else $error("remainder not below modulus");

endmodule

/* rtl/core/ewpe_back.sv */
`timescale 1ns / 1ps
// Back end: source memory, walk vertex, parity and the output register.
// Depends on ewpe_pkg and ewpe_mod_unit; takes commands from ewpe_queue.
module ewpe_back #(
  parameter int unsigned HALF_BITS = ewpe_pkg::HALF_BITS_DEF,
  parameter int unsigned WORD_BITS = ewpe_pkg::WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ewpe_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  ewpe_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  output ewpe_pkg::out_word_t out_word_o,
  input  logic                out_stall_i
);
  import ewpe_pkg::*;

  localparam int unsigned VW    = 2 * HALF_BITS;
  localparam int unsigned H_W   = $clog2(HALF_BITS + 1);
  localparam int unsigned VAL_W = HALF_BITS + SIDE_W + 1;
  localparam int unsigned CW    = VW + 7;
  localparam int unsigned R_W   = $clog2(2 * WORD_BITS);
  localparam int unsigned BI_W  = $clog2(WORD_BITS);
  localparam logic [VW-1:0]  RECIP = VW'((64'd1 << VW) / WORD_BITS);
  localparam logic [R_W-1:0] WB_R  = R_W'(WORD_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_MUL,
    S_QUOT,
    S_FIX,
    S_FOLD,
    S_MOD_GO,
    S_MOD_WAIT,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [VW-1:0]       vertex_q;
  logic                parity_q;
  logic                out_valid_q;
  out_word_t           out_word_q;

  cmd_t                cmd_q;
  logic [2*VW-1:0]     prod_q;
  logic [VW-1:0]       q0_q;
  logic [R_W-1:0]      r0_q;
  logic [BI_W-1:0]     bit_idx_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] source_mem [STORE_DEPTH];

  logic [H_W-1:0]       eff_h;
  logic [HALF_BITS:0]   cmask_w;
  logic [HALF_BITS-1:0] cmask;
  logic [VW-1:0]        vshift;
  logic [HALF_BITS-1:0] x_cur, y_cur, base, other, newc, x_new, y_new;
  logic [HALF_BITS:0]   delta;
  logic [SIDE_W-1:0]    m_eff;
  logic [VAL_W-1:0]     mod_value;
  logic                 mod_done;
  logic [SIDE_W-1:0]    mod_rem;
  logic [VW-1:0]        vertex_step;
  logic [CW-1:0]        r0_full;
  logic [VW-1:0]        q_fix;
  logic [R_W-1:0]       r_fix;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 emit_ok;

  assign eff_h   = H_W'(eff_half(cfg_i.half_bits, HALF_BITS));
  assign cmask_w = ({{HALF_BITS{1'b0}}, 1'b1} << eff_h) - {{HALF_BITS{1'b0}}, 1'b1};
  assign cmask   = cmask_w[HALF_BITS-1:0];
  assign vshift  = vertex_q >> eff_h;
  assign x_cur   = vertex_q[HALF_BITS-1:0] & cmask;
  assign y_cur   = vshift[HALF_BITS-1:0] & cmask;
  assign base    = cmd_q.step_y ? y_cur : x_cur;
  assign other   = cmd_q.step_y ? x_cur : y_cur;
  assign delta   = {other, cmd_q.step_odd};
  assign m_eff   = (cfg_i.side == '0) ? SIDE_W'(1) : cfg_i.side;

  // Subtraction is made nonnegative by adding a multiple of the modulus.
  always_comb begin
    if (cmd_q.step_sub) begin
      mod_value = VAL_W'(base) + (VAL_W'(m_eff) << (HALF_BITS + 1)) - VAL_W'(delta);
    end else begin
      mod_value = VAL_W'(base) + VAL_W'(delta);
    end
  end

  ewpe_mod_unit #(
    .VALUE_W (VAL_W)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_MOD_GO),
    .value_i   (mod_value),
    .modulus_i (m_eff),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign newc        = HALF_BITS'(mod_rem) & cmask;
  assign x_new       = cmd_q.step_y ? x_cur : newc;
  assign y_new       = cmd_q.step_y ? newc : y_cur;
  assign vertex_step = VW'(x_new) | (VW'(y_new) << eff_h);

  // The quotient estimate from the reciprocal is low by at most one.
  assign r0_full = CW'(vertex_q) - CW'(prod_q[2*VW-1:VW]) * CW'(WORD_BITS);

  always_comb begin
    if (r0_q >= WB_R) begin
      q_fix = q0_q + VW'(1);
      r_fix = r0_q - WB_R;
    end else begin
      q_fix = q0_q;
      r_fix = r0_q;
    end
  end
  assign rd_addr = ADDR_W'(q_fix);

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign emit_ok   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vertex_q    <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (state_q == S_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              MODE_LOAD:  state_q <= S_LOAD;
              MODE_START: state_q <= S_START;
              MODE_CHECK: state_q <= S_MUL;
              MODE_STEP:  state_q <= S_MOD_GO;
              default:    state_q <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          state_q <= S_EMIT;
        end
        S_START: begin
          vertex_q <= VW'(cmd_q.start_vertex);
          parity_q <= 1'b0;
          state_q  <= S_EMIT;
        end
        S_MUL: begin
          state_q <= S_QUOT;
        end
        S_QUOT: begin
          state_q <= S_FIX;
        end
        S_FIX: begin
          state_q <= S_FOLD;
        end
        S_FOLD: begin
          parity_q <= parity_q ^ (rdata_q[bit_idx_q] & cmd_q.select_bit);
          state_q  <= S_EMIT;
        end
        S_MOD_GO: begin
          state_q <= S_MOD_WAIT;
        end
        S_MOD_WAIT: begin
          if (mod_done) begin
            vertex_q <= vertex_step;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_word_q.parity <= parity_q;
            out_word_q.vertex <= VERTEX_W'(vertex_q);
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= (2*VW)'(vertex_q) * (2*VW)'(RECIP);
    end
    if (state_q == S_QUOT) begin
      q0_q <= prod_q[2*VW-1:VW];
      r0_q <= R_W'(r0_full);
    end
    if (state_q == S_FIX) begin
      bit_idx_q <= BI_W'(r_fix);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      source_mem[ADDR_W'(cmd_q.word_index)] <= WORD_BITS'(cmd_q.word_data);
    end
    if (state_q == S_FIX) begin
      rdata_q <= source_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_bit_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD) |-> (32'(bit_idx_q) < WORD_BITS))
    else $error("bit offset beyond source word");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !emit_ok) |=> (state_q == S_EMIT && out_valid_q))
    else $error("result left before the output register was free");

endmodule

/* rtl/core/expander_walk_parity_extractor_top.sv */
`timescale 1ns / 1ps
// Top level of the expander walk parity extractor: configuration registers,
// front end, command queue and back end. Depends on ewpe_pkg and all ewpe_ modules.
//
//   channel  direction  handshake                   word
//   in       input      in_valid_i / in_stall_o     ewpe_pkg::in_word_t
//   out      output     out_valid_o / out_stall_i   ewpe_pkg::out_word_t
//   cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Each word yields one result word. After leaving the queue, a load or a start
// passes through its own state, a check through the reciprocal multiply, the
// correction and memory read and the parity fold, and a step through the
// remainder unit that retires four bits a cycle; each then waits to emit.
// Reset is asynchronous and active low; the source memory is not cleared.
// A two-word queue lets the input run ahead while a result waits on out_stall_i.
module expander_walk_parity_extractor_top #(
  parameter int unsigned HALF_BITS = ewpe_pkg::HALF_BITS_DEF,
  parameter int unsigned WORD_BITS = ewpe_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  ewpe_pkg::in_word_t             in_word_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output ewpe_pkg::out_word_t            out_word_o,
  input  logic                           out_stall_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ewpe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ewpe_pkg::SIDE_W-1:0]    cfg_data_i
);
  import ewpe_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  logic push, pop, queue_full, queue_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side      <= SIDE_RESET;
      cfg_q.half_bits <= HALF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SIDE:      cfg_q.side      <= cfg_data_i;
        CFG_HALF_BITS: cfg_q.half_bits <= cfg_data_i[HALF_CFG_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  ewpe_front #(
    .HALF_BITS (HALF_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .in_stall_o   (in_stall_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  ewpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  ewpe_back #(
    .HALF_BITS (HALF_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* tb/tb_expander_walk_parity_extractor_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for expander_walk_parity_extractor_top: random expander walks with
// source loads, checks and steps under register sweeps, idling and output back-pressure.
// Depends on ewpe_pkg and the RTL of the block; every word is checked against a local predictor.
module tb_expander_walk_parity_extractor_top;
  import ewpe_pkg::*;

  localparam int unsigned CORE_HALF   = HALF_BITS_DEF;
  localparam int unsigned SRC_WORD    = WORD_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned IDLE_PCT    = 11;

  localparam int unsigned EDGE_SUB_BIT = 0;
  localparam int unsigned EDGE_ODD_BIT = 1;
  localparam int unsigned EDGE_Y_BIT   = 2;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  in_word_t             in_word_i;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_word_t            out_word_o;
  logic                 out_stall_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIDE_W-1:0]    cfg_data_i;

  expander_walk_parity_extractor_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  logic [SIDE_W-1:0]     walk_side;
  logic [HALF_CFG_W-1:0] walk_half;
  logic [VERTEX_W-1:0]   walk_vertex;
  logic                  walk_parity;
  logic [DATA_W-1:0]     source_bits [int unsigned];

  out_word_t   expected_results [$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned err_count;
  int unsigned settings_used;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  bit          calm;

  function automatic longint unsigned move_coord(longint unsigned base, longint unsigned delta,
                                                 bit minus, longint unsigned m);
    longint unsigned b, d;
    b = base % m;
    d = delta % m;
    return minus ? (b + m - d) % m : (b + d) % m;
  endfunction

  function automatic int unsigned used_half();
    return (int'(walk_half) > CORE_HALF) ? CORE_HALF : int'(walk_half);
  endfunction

  function automatic int unsigned source_word_of(logic [VERTEX_W-1:0] v);
    return (int'(v) / SRC_WORD) % STORE_DEPTH;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    longint unsigned cmask, m, x, y, delta;
    int unsigned     h, wi;
    logic            src_bit;
    out_word_t       r;
    h = used_half();
    cmask = (64'd1 << h) - 1;
    case (mode_e'(w.mode))
      MODE_LOAD: begin
        source_bits[w.word_index] = w.word_data;
      end
      MODE_START: begin
        walk_vertex = VERTEX_W'(longint'(w.start_vertex) & ((64'd1 << (2 * h)) - 1));
        walk_parity = 1'b0;
      end
      MODE_CHECK: begin
        wi = source_word_of(walk_vertex);
        src_bit = source_bits.exists(wi) ? source_bits[wi][int'(walk_vertex) % SRC_WORD] : 1'b0;
        walk_parity = walk_parity ^ (src_bit & w.select_bit);
      end
      default: begin
        m = (walk_side == '0) ? 1 : longint'(walk_side);
        x = longint'(walk_vertex) & cmask;
        y = (longint'(walk_vertex) >> h) & cmask;
        if (!w.edge_req[EDGE_Y_BIT]) begin
          delta = 2 * y + w.edge_req[EDGE_ODD_BIT];
          x = move_coord(x, delta, w.edge_req[EDGE_SUB_BIT], m);
        end else begin
          delta = 2 * x + w.edge_req[EDGE_ODD_BIT];
          y = move_coord(y, delta, w.edge_req[EDGE_SUB_BIT], m);
        end
        walk_vertex = VERTEX_W'((x & cmask) | ((y & cmask) << h));
      end
    endcase
    r.parity = walk_parity;
    r.vertex = walk_vertex;
    return r;
  endfunction

  task automatic report_miss(string what, out_word_t e, out_word_t a);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected parity %0b vertex 0x%05h, got parity %0b vertex 0x%05h",
               $realtime, what, e.parity, e.vertex, a.parity, a.vertex);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_miss("result with nothing pending", '0, out_word_o);
      end else begin
        exp_w = expected_results.pop_front();
        if (out_word_o.parity !== exp_w.parity || out_word_o.vertex !== exp_w.vertex) begin
          report_miss("result mismatch", exp_w, out_word_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_expander_walk_parity_extractor_top failed");
      $finish;
    end
  end

  function automatic in_word_t random_word(mode_e m);
    logic [127:0] r;
    in_word_t     w;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    w = r[$bits(in_word_t)-1:0];
    w.mode = m;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_results.push_back(predict_result(w));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_load(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    in_word_t w;
    w = random_word(MODE_LOAD);
    w.word_index = idx;
    w.word_data = data;
    send_word(w);
  endtask

  task automatic send_start(logic [VERTEX_W-1:0] v);
    in_word_t w;
    w = random_word(MODE_START);
    w.start_vertex = v;
    send_word(w);
  endtask

  // The source word under the vertex is loaded first if it was never written.
  task automatic send_check(logic sel);
    in_word_t w;
    int unsigned wi;
    wi = source_word_of(walk_vertex);
    if (!source_bits.exists(wi)) begin
      send_load(INDEX_W'(wi), {$urandom(), $urandom()});
    end
    w = random_word(MODE_CHECK);
    w.select_bit = sel;
    send_word(w);
  endtask

  task automatic send_step(logic [EDGE_W-1:0] e);
    in_word_t w;
    w = random_word(MODE_STEP);
    w.edge_req = e;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_SIDE) begin
      walk_side = data;
    end else begin
      walk_half = data[HALF_CFG_W-1:0];
    end
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [SIDE_W-1:0] side_val, logic [HALF_CFG_W-1:0] half_val);
    wait_drained();
    write_reg(CFG_SIDE, side_val);
    write_reg(CFG_HALF_BITS, {SIDE_W'($urandom_range(0, 127)) << HALF_CFG_W} | half_val);
    cfg_valid_i <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic run_walks(int unsigned n_words);
    int unsigned stop_at, rounds, len;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        send_start(VERTEX_W'($urandom()));
        rounds = $urandom_range(1, 4);
        len = $urandom_range(2, 8);
        repeat (rounds) begin
          send_check($urandom_range(0, 9) != 0);
          repeat (len - 1) send_step(EDGE_W'($urandom()));
        end
      end else begin
        case (mode_e'($urandom_range(0, 3)))
          MODE_LOAD:  send_word(random_word(MODE_LOAD));
          MODE_START: send_word(random_word(MODE_START));
          MODE_CHECK: send_check(1'($urandom()));
          default:    send_word(random_word(MODE_STEP));
        endcase
      end
    end
  endtask

  task automatic test_directed();
    send_load(INDEX_W'(STORE_DEPTH - 1), '1);
    send_load('0, 64'h8000_0000_0000_0001);
    send_load(INDEX_W'(1), '0);
    send_start('1);
    send_check(1'b1);
    send_check(1'b0);
    send_start('0);
    send_check(1'b1);
    for (int e = 0; e < 8; e++) begin
      send_step(EDGE_W'(e));
    end
    send_check(1'b1);
    send_start(20'h003FF);
    send_step(EDGE_W'(1));
    send_step(EDGE_W'(7));
    send_check(1'b1);
  endtask

  task automatic test_register_sweep();
    int unsigned sweep_side [10] = '{2, 0, 7, 1000, 2047, 16, 6, 300, 1, 1024};
    int unsigned sweep_half [10] = '{1, 3, 3, 12, 15, 0, 3, 5, 10, 10};
    for (int i = 0; i < 10; i++) begin
      set_config(SIDE_W'(sweep_side[i]), HALF_CFG_W'(sweep_half[i]));
      run_walks(80);
    end
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    run_walks(40);
    wait_drained();
  endtask

  task automatic test_random();
    run_walks(300);
    wait_drained();
    calm = 1'b1;
    run_walks(250);
    calm = 1'b0;
    run_walks(350);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SIDE;
    cfg_data_i  = '0;
    walk_side   = SIDE_RESET;
    walk_half   = HALF_RESET;
    walk_vertex = '0;
    walk_parity = 1'b0;
    words_sent = 0;
    results_seen = 0;
    err_count = 0;
    settings_used = 1;
    cycle_cnt = 0;
    hold_left = 0;
    calm = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Sent %0d words and checked %0d results over %0d register settings,",
             words_sent, results_seen, settings_used);
    $display("%0d source words loaded, %0d mismatches.", source_bits.num(), err_count);
    if (err_count == 0) begin
      $display("tb_expander_walk_parity_extractor_top passed");
    end else begin
      $display("tb_expander_walk_parity_extractor_top failed");
    end
    $finish;
  end

endmodule
